// ===== sv/dq_pkg.sv =====
`timescale 1ns / 1ps

package dq_pkg;

  typedef logic signed [31:0] word_t;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_REAR   = 3'd3;
  localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [2:0] REQ_PEEK_REAR  = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    word_t      push_value;
  } dq_req_t;

  typedef struct packed {
    word_t      read_value;
    logic [1:0] status;
    logic [4:0] occupancy;
  } dq_rsp_t;

  // What every cell of a chain does on a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_APPEND
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    data;
  } cell_cmd_t;

endpackage

// ===== sv/double_ended_queue_top.sv =====
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words, up to DEPTH entries.
// Requests come in on req (req_valid / req_stall); each gives one word on
// rsp (rsp_valid / rsp_stall) with the popped or peeked value, a status
// (ok, empty on pop or peek, full on push) and the occupancy afterwards.
// The entries sit twice, in two rows of cells: one row keeps the front
// word in its first cell, the other keeps the rear word there. Pushes
// shift one row by a cell and append to the other at the count; pops
// shift the row whose end they take. Every read comes from a first cell.
// rsp_valid rises in the cycle after a request is accepted; one request is
// taken every cycle while no response is held by rsp_stall.
// A response held by rsp_stall holds req_stall high until it is taken, so
// nothing is lost while the receiver stalls.
// Reset empties the queue and drops any pending response; word contents
// are not cleared and no clearing pass is needed.
// Occupancy reports the count masked to five bits.
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  dq_req_t req,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output dq_rsp_t rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  cell_cmd_t        cmd_front;
  cell_cmd_t        cmd_rear;
  word_t            front_word;
  word_t            rear_word;
  dq_rsp_t          result;

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    cmd_front      = '{op: CELL_HOLD, data: req.push_value};
    cmd_rear       = '{op: CELL_HOLD, data: req.push_value};
    count_next     = count;
    result.read_value = '0;
    result.status  = ST_OK;
    unique case (req.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
        if (full) begin
          result.status = ST_FULL;
        end else begin
          count_next = count + 1'b1;
          if (req.req_type == REQ_PUSH_FRONT) begin
            cmd_front.op = CELL_INSERT;
            cmd_rear.op  = CELL_APPEND;
          end else begin
            cmd_front.op = CELL_APPEND;
            cmd_rear.op  = CELL_INSERT;
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_REAR, REQ_PEEK_FRONT, REQ_PEEK_REAR: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          if (req.req_type == REQ_POP_FRONT || req.req_type == REQ_PEEK_FRONT) begin
            result.read_value = front_word;
          end else begin
            result.read_value = rear_word;
          end
          // a pop drops the end word from its own row; the other row just
          // loses its last entry through the count
          if (req.req_type == REQ_POP_FRONT) begin
            cmd_front.op = CELL_REMOVE;
            count_next   = count - 1'b1;
          end else if (req.req_type == REQ_POP_REAR) begin
            cmd_rear.op = CELL_REMOVE;
            count_next  = count - 1'b1;
          end
        end
      end
      default: ;
    endcase
    result.occupancy = 5'(count_next);
    if (!accept) begin
      cmd_front.op = CELL_HOLD;
      cmd_rear.op  = CELL_HOLD;
    end
  end

  dq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front_chain (
    .clk   (clk),
    .cmd   (cmd_front),
    .count (count),
    .head  (front_word)
  );

  dq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_rear_chain (
    .clk   (clk),
    .cmd   (cmd_rear),
    .count (count),
    .head  (rear_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= result;
    end
  end

endmodule

// ===== sv/dq_cell.sv =====
`timescale 1ns / 1ps

module dq_cell
  import dq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      sel,
  input  word_t     lower,
  input  word_t     upper,
  output word_t     word
);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_INSERT: word <= lower;
      CELL_REMOVE: word <= upper;
      CELL_APPEND: begin
        if (sel) begin
          word <= cmd.data;
        end
      end
      CELL_HOLD: word <= word;
      default:   word <= word;
    endcase
  end

endmodule

// ===== sv/dq_chain.sv =====
`timescale 1ns / 1ps

module dq_chain
  import dq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [CNT_W-1:0] count,
  output word_t            head
);

  word_t cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lower;
    word_t upper;
    logic  sel;

    // cell 0 takes the new word on insert; the last cell has nothing above it
    if (i == 0) begin : g_first
      assign lower = cmd.data;
    end else begin : g_mid_lo
      assign lower = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = cmd.data;
    end else begin : g_mid_hi
      assign upper = cells[i+1];
    end

    assign sel = (count == CNT_W'(i));

    dq_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .sel   (sel),
      .lower (lower),
      .upper (upper),
      .word  (cells[i])
    );
  end

  assign head = cells[0];

endmodule
